// ===== src/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg: shared types and constants of the scaled glyph blitter
// Screen geometry, field widths, operation codes and the item/result structs.
// ----------------------------------------------------------------------------
package sgb_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int MAX_SCALE     = 8;

  localparam int NUM_PAGES   = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = NUM_PAGES * SCREEN_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int ROWS_PAD    = NUM_PAGES * 8;

  // Glyph shape
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int COL_W      = 3;
  localparam int ROW_W      = 3;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int OX_W    = 10;
  localparam int OY_W    = 9;
  localparam int SCALE_W = 4;
  localparam int IDX_W   = 10;
  localparam int DATA_W  = 8;

  // Internal coordinate widths
  localparam int CX_W   = 11;
  localparam int PX_W   = 12;
  localparam int YPOS_W = 11;

  localparam int CURSOR_X_MAX = (1 << (CX_W - 1)) - 1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_DRAW  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]                       func;
    logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0]   gcol;
    logic                                    start_text;
    logic signed [OX_W-1:0]                  origin_x;
    logic signed [OY_W-1:0]                  origin_y;
    logic [SCALE_W-1:0]                      pixel_scale;
    logic [IDX_W-1:0]                        read_index;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } result_t;

  // Map scale zero to one and cap at the largest supported scale
  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] s);
    logic [SCALE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SCALE_W'(1);
    end else if (s > SCALE_W'(MAX_SCALE)) begin
      r = SCALE_W'(MAX_SCALE);
    end
    return r;
  endfunction

endpackage

// ===== src/sgb_ram.sv =====
// ----------------------------------------------------------------------------
// sgb_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sgb_window.sv =====
// ----------------------------------------------------------------------------
// sgb_window: scaled row window unit
// Marks the screen rows covered by one glyph row scaled to a block of height
// scale starting at a signed row position, clipped to the screen.
// ----------------------------------------------------------------------------
module sgb_window (
  input  logic signed [sgb_pkg::YPOS_W-1:0]  ypos,
  input  logic        [sgb_pkg::SCALE_W-1:0] scale,
  output logic        [sgb_pkg::ROWS_PAD-1:0] block
);

  logic signed [sgb_pkg::YPOS_W:0] lo_ext;
  logic signed [sgb_pkg::YPOS_W:0] hi_ext;
  logic signed [sgb_pkg::YPOS_W:0] row_pos;

  // Compare every screen row against the window bounds
  always_comb begin
    lo_ext  = {ypos[sgb_pkg::YPOS_W-1], ypos};
    hi_ext  = lo_ext + $signed({{(sgb_pkg::YPOS_W + 1 - sgb_pkg::SCALE_W){1'b0}}, scale});
    row_pos = '0;
    block   = '0;
    for (int i = 0; i < sgb_pkg::ROWS_PAD; i++) begin
      row_pos  = $signed((sgb_pkg::YPOS_W + 1)'(i));
      block[i] = (row_pos >= lo_ext) && (row_pos < hi_ext) && (i < sgb_pkg::SCREEN_HEIGHT);
    end
  end

endmodule

// ===== src/sgb_engine.sv =====
// ----------------------------------------------------------------------------
// sgb_engine: blitter sequencer
// Clears the store, builds the scaled column masks row by row through the
// window unit, then walks each screen column and page doing read-modify-write
// into the frame store. Also serves byte reads and keeps the text cursor.
// ----------------------------------------------------------------------------
module sgb_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  sgb_pkg::item_t                      item,
  output logic                                idle,
  input  logic                                out_free,
  output sgb_pkg::result_t                    res,
  output logic                                ram_we,
  output logic [sgb_pkg::ADDR_W-1:0]          ram_waddr,
  output logic [sgb_pkg::DATA_W-1:0]          ram_wdata,
  output logic [sgb_pkg::ADDR_W-1:0]          ram_raddr,
  input  logic [sgb_pkg::DATA_W-1:0]          ram_rdata,
  output logic signed [sgb_pkg::YPOS_W-1:0]   win_ypos,
  output logic [sgb_pkg::SCALE_W-1:0]         win_scale,
  input  logic [sgb_pkg::ROWS_PAD-1:0]        win_block
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ROWS = 3'd2;
  localparam logic [2:0] ST_COLS = 3'd3;
  localparam logic [2:0] ST_PAGE = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_RD   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [sgb_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic signed [sgb_pkg::CX_W-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [sgb_pkg::OY_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [sgb_pkg::SCALE_W-1:0] cursor_scale_r, cursor_scale_nxt;

  logic [sgb_pkg::GLYPH_COLS-1:0][sgb_pkg::GLYPH_ROWS-1:0] gcol_r, gcol_nxt;
  logic [sgb_pkg::GLYPH_COLS-1:0][sgb_pkg::ROWS_PAD-1:0] mask_r, mask_nxt;
  logic signed [sgb_pkg::YPOS_W-1:0] ypos_r, ypos_nxt;
  logic signed [sgb_pkg::PX_W-1:0] px_r, px_nxt;
  logic [sgb_pkg::ROW_W-1:0] r_r, r_nxt;
  logic [sgb_pkg::COL_W-1:0] c_r, c_nxt;
  logic [sgb_pkg::SCALE_W-1:0] dx_r, dx_nxt;
  logic [sgb_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [sgb_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [sgb_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [sgb_pkg::DATA_W-1:0] res_data_r, res_data_nxt;

  logic [sgb_pkg::SCALE_W-1:0] s_new;
  logic signed [sgb_pkg::PX_W-1:0] x0_ext;
  logic signed [sgb_pkg::PX_W-1:0] six_s;
  logic signed [sgb_pkg::PX_W-1:0] x_sum;
  logic signed [sgb_pkg::OY_W-1:0] y0;
  logic [sgb_pkg::ROWS_PAD-1:0] cur_mask;
  logic [sgb_pkg::DATA_W-1:0] page_byte;
  logic [sgb_pkg::ADDR_W-1:0] px_addr;
  logic on_screen;
  logic page_last;
  logic col_last;
  logic dx_last;
  logic do_adv;
  logic do_page_step;

  // Column mask byte for the current column and page
  always_comb begin
    cur_mask  = mask_r[c_r];
    page_byte = cur_mask[{page_r, 3'b000} +: 8];
    px_addr   = sgb_pkg::ADDR_W'(px_r);
    on_screen = (px_r >= 0) && (px_r < sgb_pkg::SCREEN_WIDTH);
    page_last = (page_r == sgb_pkg::PAGE_W'(sgb_pkg::NUM_PAGES - 1));
    dx_last   = (dx_r == cursor_scale_r - sgb_pkg::SCALE_W'(1));
    col_last  = (c_r == sgb_pkg::COL_W'(sgb_pkg::GLYPH_COLS - 1)) && dx_last;
  end

  // Cursor set-up for a draw item
  always_comb begin
    if (item.start_text) begin
      s_new  = sgb_pkg::clamp_scale(item.pixel_scale);
      x0_ext = sgb_pkg::PX_W'(item.origin_x);
      y0     = item.origin_y;
    end else begin
      s_new  = cursor_scale_r;
      x0_ext = sgb_pkg::PX_W'(cursor_x_r);
      y0     = cursor_y_r;
    end
    six_s = $signed((sgb_pkg::PX_W'(s_new) << 2) + (sgb_pkg::PX_W'(s_new) << 1));
    x_sum = x0_ext + six_s;
  end

  // Shared window unit sees the current row block
  assign win_ypos  = ypos_r;
  assign win_scale = cursor_scale_r;

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    clr_nxt          = clr_r;
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    cursor_scale_nxt = cursor_scale_r;
    gcol_nxt         = gcol_r;
    mask_nxt         = mask_r;
    ypos_nxt         = ypos_r;
    px_nxt           = px_r;
    r_nxt            = r_r;
    c_nxt            = c_r;
    dx_nxt           = dx_r;
    page_nxt         = page_r;
    base_nxt         = base_r;
    addr_nxt         = addr_r;
    res_data_nxt     = res_data_r;
    ram_we           = 1'b0;
    ram_waddr        = addr_r;
    ram_wdata        = ram_rdata | page_byte;
    ram_raddr        = base_r + px_addr;
    res.valid        = 1'b0;
    res.data         = res_data_r;
    do_adv           = 1'b0;
    do_page_step     = 1'b0;

    unique case (state_r)
      // Sweep zeros through the whole store
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + sgb_pkg::ADDR_W'(1);
        if (clr_r == sgb_pkg::ADDR_W'(sgb_pkg::STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      // Take the next item
      ST_IDLE: begin
        ram_raddr = sgb_pkg::ADDR_W'(item.read_index);
        if (go) begin
          case (item.func)
            sgb_pkg::FN_DRAW: begin
              cursor_scale_nxt = s_new;
              cursor_y_nxt     = y0;
              if (x_sum > sgb_pkg::PX_W'(sgb_pkg::CURSOR_X_MAX)) begin
                cursor_x_nxt = sgb_pkg::CX_W'(sgb_pkg::CURSOR_X_MAX);
              end else begin
                cursor_x_nxt = sgb_pkg::CX_W'(x_sum);
              end
              px_nxt    = x0_ext;
              ypos_nxt  = sgb_pkg::YPOS_W'(y0);
              gcol_nxt  = item.gcol;
              mask_nxt  = '0;
              r_nxt     = '0;
              state_nxt = ST_ROWS;
            end
            sgb_pkg::FN_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            sgb_pkg::FN_READ: begin
              if (32'(item.read_index) < 32'(sgb_pkg::STORE_BYTES)) begin
                state_nxt = ST_RD;
              end else begin
                res_data_nxt = '0;
                state_nxt    = ST_OUT;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      // Build the column masks one glyph row per cycle
      ST_ROWS: begin
        for (int k = 0; k < sgb_pkg::GLYPH_COLS; k++) begin
          if (gcol_r[k][r_r]) begin
            mask_nxt[k] = mask_r[k] | win_block;
          end
        end
        ypos_nxt = ypos_r + $signed({{(sgb_pkg::YPOS_W - sgb_pkg::SCALE_W){1'b0}},
                                     cursor_scale_r});
        r_nxt    = r_r + sgb_pkg::ROW_W'(1);
        if (r_r == sgb_pkg::ROW_W'(sgb_pkg::GLYPH_ROWS - 1)) begin
          c_nxt     = '0;
          dx_nxt    = '0;
          state_nxt = ST_COLS;
        end
      end
      // Enter the page walk for a visible column, drop clipped ones
      ST_COLS: begin
        if (on_screen) begin
          page_nxt  = '0;
          base_nxt  = '0;
          state_nxt = ST_PAGE;
        end else begin
          do_adv = 1'b1;
        end
      end
      // Issue the read for a page with pixels to set
      ST_PAGE: begin
        if (page_byte != '0) begin
          addr_nxt  = base_r + px_addr;
          state_nxt = ST_WR;
        end else begin
          do_page_step = 1'b1;
        end
      end
      // Merge the pixels and write back
      ST_WR: begin
        ram_we       = 1'b1;
        do_page_step = 1'b1;
      end
      // Capture the read byte
      ST_RD: begin
        res_data_nxt = ram_rdata;
        state_nxt    = ST_OUT;
      end
      // Hand the result over once the output register is free
      ST_OUT: begin
        res.valid = 1'b1;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase

    // Advance to the next page, or the next column after the last page
    if (do_page_step) begin
      if (page_last) begin
        do_adv = 1'b1;
      end else begin
        page_nxt  = page_r + sgb_pkg::PAGE_W'(1);
        base_nxt  = base_r + sgb_pkg::ADDR_W'(sgb_pkg::SCREEN_WIDTH);
        state_nxt = ST_PAGE;
      end
    end

    // Advance to the next screen column of the glyph
    if (do_adv) begin
      px_nxt = px_r + sgb_pkg::PX_W'(1);
      if (dx_last) begin
        dx_nxt = '0;
        c_nxt  = c_r + sgb_pkg::COL_W'(1);
      end else begin
        dx_nxt = dx_r + sgb_pkg::SCALE_W'(1);
      end
      state_nxt = col_last ? ST_IDLE : ST_COLS;
    end
  end

  assign idle = (state_r == ST_IDLE);

  // Control state and cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      clr_r          <= '0;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      cursor_scale_r <= sgb_pkg::SCALE_W'(1);
    end else begin
      state_r        <= state_nxt;
      clr_r          <= clr_nxt;
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      cursor_scale_r <= cursor_scale_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    gcol_r     <= gcol_nxt;
    mask_r     <= mask_nxt;
    ypos_r     <= ypos_nxt;
    px_r       <= px_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    dx_r       <= dx_nxt;
    page_r     <= page_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    res_data_r <= res_data_nxt;
  end

  // A write-back always comes straight after the page state that issued its read
  a_wr_after_page: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> $past(state_r) == ST_PAGE)
    else $error("write-back without preceding read");

  // Only columns on the screen reach the page walk
  a_page_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PAGE |-> (px_r >= 0 && px_r < sgb_pkg::SCREEN_WIDTH))
    else $error("page walk on clipped column");

  // The clearing sweep ends only after the last byte
  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && $past(state_r) == ST_CLR)
      |-> $past(clr_r) == sgb_pkg::ADDR_W'(sgb_pkg::STORE_BYTES - 1))
    else $error("clearing sweep left early");

endmodule

// ===== src/scaled_glyph_blitter_core.sv =====
// ----------------------------------------------------------------------------
// scaled_glyph_blitter_core: page-organised framebuffer with scaled glyph blit
// Draws 5x7 glyphs at scales 1 to 8 into a 1-bit column-byte frame store, clears
// it and reads single bytes back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  func, glyph columns, cursor, index
//   out_     output     out_valid/out_stall  read_data (read items only)
//
// Items: one item at a time; in_stall is high while an item is being worked.
//   Clear and reset: one store byte per cycle over all STORE_BYTES (1024) bytes.
//   Read: ST_RD captures the byte, ST_OUT loads the output register; an index
//   beyond the store skips ST_RD and returns zero. Draw: masks built over the
//   seven glyph rows, then each of the 5*scale glyph columns: a clipped one is
//   dropped, else every page is visited and one with pixels to set is read and written back.
// Reset clears the frame store with the sweep above and homes the cursor.
// A waiting result holds in the output register; the next item is still taken,
// but a second read result waits in the sequencer with in_stall held high.
// ----------------------------------------------------------------------------
module scaled_glyph_blitter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sgb_pkg::FUNC_W-1:0]            in_func,
  input  logic [sgb_pkg::GLYPH_ROWS-1:0]        in_glyph_col0,
  input  logic [sgb_pkg::GLYPH_ROWS-1:0]        in_glyph_col1,
  input  logic [sgb_pkg::GLYPH_ROWS-1:0]        in_glyph_col2,
  input  logic [sgb_pkg::GLYPH_ROWS-1:0]        in_glyph_col3,
  input  logic [sgb_pkg::GLYPH_ROWS-1:0]        in_glyph_col4,
  input  logic                                  in_start_text,
  input  logic signed [sgb_pkg::OX_W-1:0]       in_origin_x,
  input  logic signed [sgb_pkg::OY_W-1:0]       in_origin_y,
  input  logic [sgb_pkg::SCALE_W-1:0]           in_pixel_scale,
  input  logic [sgb_pkg::IDX_W-1:0]             in_read_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [sgb_pkg::DATA_W-1:0]            out_read_data
);

  sgb_pkg::item_t   item;
  sgb_pkg::result_t res;
  logic idle;
  logic go;
  logic out_free;
  logic out_valid_r;
  logic [sgb_pkg::DATA_W-1:0] out_read_data_r;

  logic ram_we;
  logic [sgb_pkg::ADDR_W-1:0] ram_waddr;
  logic [sgb_pkg::DATA_W-1:0] ram_wdata;
  logic [sgb_pkg::ADDR_W-1:0] ram_raddr;
  logic [sgb_pkg::DATA_W-1:0] ram_rdata;
  logic signed [sgb_pkg::YPOS_W-1:0] win_ypos;
  logic [sgb_pkg::SCALE_W-1:0] win_scale;
  logic [sgb_pkg::ROWS_PAD-1:0] win_block;

  // Gather the item fields
  always_comb begin
    item.func        = in_func;
    item.gcol[0]     = in_glyph_col0;
    item.gcol[1]     = in_glyph_col1;
    item.gcol[2]     = in_glyph_col2;
    item.gcol[3]     = in_glyph_col3;
    item.gcol[4]     = in_glyph_col4;
    item.start_text  = in_start_text;
    item.origin_x    = in_origin_x;
    item.origin_y    = in_origin_y;
    item.pixel_scale = in_pixel_scale;
    item.read_index  = in_read_index;
  end

  assign in_stall = !idle;
  assign go       = in_valid && idle;
  assign out_free = !out_valid_r || !out_stall;

  sgb_ram #(
    .WIDTH (sgb_pkg::DATA_W),
    .DEPTH (sgb_pkg::STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sgb_window u_win (
    .ypos  (win_ypos),
    .scale (win_scale),
    .block (win_block)
  );

  sgb_engine u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (item),
    .idle      (idle),
    .out_free  (out_free),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .win_ypos  (win_ypos),
    .win_scale (win_scale),
    .win_block (win_block)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      out_read_data_r <= res.data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

endmodule

// ===== sim/scaled_glyph_blitter_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scaled_glyph_blitter_core_test: self-checking bench for the glyph blitter
// Sends draw, clear, read and ignored items with random idle gaps on both channels. It
// keeps its own image of the frame store and the text cursor, and compares
// every byte read back with that image.
// ----------------------------------------------------------------------------
module scaled_glyph_blitter_core_test;

  // Function code that the block ignores
  localparam logic [sgb_pkg::FUNC_W-1:0] FN_NONE = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef logic [sgb_pkg::GLYPH_COLS-1:0][sgb_pkg::GLYPH_ROWS-1:0] glyph_t;

  typedef struct {
    int unsigned                index;
    logic [sgb_pkg::DATA_W-1:0] data;
  } read_expect_t;

  logic                              clk            = 1'b0;
  logic                              rst_n          = 1'b0;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic [sgb_pkg::FUNC_W-1:0]        in_func        = '0;
  logic [sgb_pkg::GLYPH_ROWS-1:0]    in_glyph_col0  = '0;
  logic [sgb_pkg::GLYPH_ROWS-1:0]    in_glyph_col1  = '0;
  logic [sgb_pkg::GLYPH_ROWS-1:0]    in_glyph_col2  = '0;
  logic [sgb_pkg::GLYPH_ROWS-1:0]    in_glyph_col3  = '0;
  logic [sgb_pkg::GLYPH_ROWS-1:0]    in_glyph_col4  = '0;
  logic                              in_start_text  = 1'b0;
  logic signed [sgb_pkg::OX_W-1:0]   in_origin_x    = '0;
  logic signed [sgb_pkg::OY_W-1:0]   in_origin_y    = '0;
  logic [sgb_pkg::SCALE_W-1:0]       in_pixel_scale = '0;
  logic [sgb_pkg::IDX_W-1:0]         in_read_index  = '0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic [sgb_pkg::DATA_W-1:0]        out_read_data;

  // Idling controls
  bit   gaps_on  = 1'b0;
  logic stall_on = 1'b0;
  logic out_hold = 1'b0;
  int   stall_left = 0;

  // Image of the frame store and the text cursor
  logic [sgb_pkg::DATA_W-1:0] fb_image [sgb_pkg::STORE_BYTES];
  int text_x     = 0;
  int text_y     = 0;
  int text_scale = 1;
  read_expect_t read_data_q [$];

  // Tallies
  int mismatches   = 0;
  int n_checked    = 0;
  int n_draws      = 0;
  int n_runs       = 0;
  int n_pinned     = 0;
  int n_reads      = 0;
  int n_busy_reads = 0;
  int n_clears     = 0;
  int n_ignored    = 0;
  int n_held_back  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scaled_glyph_blitter_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_glyph_col0  (in_glyph_col0),
    .in_glyph_col1  (in_glyph_col1),
    .in_glyph_col2  (in_glyph_col2),
    .in_glyph_col3  (in_glyph_col3),
    .in_glyph_col4  (in_glyph_col4),
    .in_start_text  (in_start_text),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_pixel_scale (in_pixel_scale),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data)
  );

  // Advance the image by one accepted item; queue the byte a read returns
  function automatic void frame_predict(input sgb_pkg::item_t it);
    int s, px, py;
    read_expect_t e;
    case (it.func)
      sgb_pkg::FN_CLEAR: begin
        foreach (fb_image[i]) fb_image[i] = '0;
        n_clears++;
      end
      sgb_pkg::FN_READ: begin
        e.index = it.read_index;
        e.data  = (it.read_index < sgb_pkg::STORE_BYTES) ? fb_image[it.read_index] : '0;
        read_data_q.push_back(e);
        n_reads++;
        if (e.data != '0) n_busy_reads++;
      end
      sgb_pkg::FN_DRAW: begin
        // Load the cursor on a start flag, scale zero counts as one
        if (it.start_text) begin
          s = it.pixel_scale;
          if (s == 0) begin
            s = 1;
          end else if (s > sgb_pkg::MAX_SCALE) begin
            s = sgb_pkg::MAX_SCALE;
          end
          text_x     = $signed(it.origin_x);
          text_y     = $signed(it.origin_y);
          text_scale = s;
          n_runs++;
        end
        // OR each set glyph pixel in as a block, drop what falls off screen
        for (int c = 0; c < sgb_pkg::GLYPH_COLS; c++) begin
          for (int r = 0; r < sgb_pkg::GLYPH_ROWS; r++) begin
            if (it.gcol[c][r]) begin
              for (int dx = 0; dx < text_scale; dx++) begin
                for (int dy = 0; dy < text_scale; dy++) begin
                  px = text_x + c * text_scale + dx;
                  py = text_y + r * text_scale + dy;
                  if (px >= 0 && px < sgb_pkg::SCREEN_WIDTH &&
                      py >= 0 && py < sgb_pkg::SCREEN_HEIGHT) begin
                    fb_image[(py / 8) * sgb_pkg::SCREEN_WIDTH + px] |=
                      sgb_pkg::DATA_W'(1) << (py % 8);
                  end
                end
              end
            end
          end
        end
        // Step the cursor right, pinned at its limit
        text_x += 6 * text_scale;
        if (text_x > sgb_pkg::CURSOR_X_MAX) begin
          text_x = sgb_pkg::CURSOR_X_MAX;
          n_pinned++;
        end
        n_draws++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  function automatic sgb_pkg::item_t rand_item();
    sgb_pkg::item_t it;
    it.func = sgb_pkg::FUNC_W'($urandom_range(0, 3));
    for (int c = 0; c < sgb_pkg::GLYPH_COLS; c++) begin
      it.gcol[c] = sgb_pkg::GLYPH_ROWS'($urandom);
    end
    it.start_text  = 1'($urandom);
    it.origin_x    = sgb_pkg::OX_W'($urandom);
    it.origin_y    = sgb_pkg::OY_W'($urandom);
    it.pixel_scale = sgb_pkg::SCALE_W'($urandom);
    it.read_index  = sgb_pkg::IDX_W'($urandom);
    return it;
  endfunction

  function automatic sgb_pkg::item_t draw_item(input bit start, input int x, input int y,
                                               input int s, input glyph_t g);
    sgb_pkg::item_t it;
    it             = rand_item();
    it.func        = sgb_pkg::FN_DRAW;
    it.gcol        = g;
    it.start_text  = start;
    it.origin_x    = sgb_pkg::OX_W'(x);
    it.origin_y    = sgb_pkg::OY_W'(y);
    it.pixel_scale = sgb_pkg::SCALE_W'(s);
    return it;
  endfunction

  function automatic sgb_pkg::item_t read_item(input int idx);
    sgb_pkg::item_t it;
    it            = rand_item();
    it.func       = sgb_pkg::FN_READ;
    it.read_index = sgb_pkg::IDX_W'(idx);
    return it;
  endfunction

  function automatic sgb_pkg::item_t op_item(input logic [sgb_pkg::FUNC_W-1:0] fn);
    sgb_pkg::item_t it;
    it      = rand_item();
    it.func = fn;
    return it;
  endfunction

  // Mostly small scales; a few zero and a few beyond the largest
  function automatic int rand_scale();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 0;
    if (r < 50) return 1;
    if (r < 78) return $urandom_range(2, 3);
    if (r < 94) return $urandom_range(4, 6);
    return $urandom_range(7, 15);
  endfunction

  // Offer one item, hold it until taken, then idle for a random gap
  task automatic send_item(input sgb_pkg::item_t it);
    int gap, r;
    in_valid       <= 1'b1;
    in_func        <= it.func;
    in_glyph_col0  <= it.gcol[0];
    in_glyph_col1  <= it.gcol[1];
    in_glyph_col2  <= it.gcol[2];
    in_glyph_col3  <= it.gcol[3];
    in_glyph_col4  <= it.gcol[4];
    in_start_text  <= it.start_text;
    in_origin_x    <= it.origin_x;
    in_origin_y    <= it.origin_y;
    in_pixel_scale <= it.pixel_scale;
    in_read_index  <= it.read_index;
    do @(posedge clk); while (in_stall);
    frame_predict(it);
    r = $urandom_range(99);
    if (!gaps_on || r < 60) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver pacing: long hold-off on request, else random stalls
  always @(posedge clk) begin : pace_receiver
    int r;
    r = $urandom_range(99);
    if (out_hold && in_valid && in_stall) n_held_back++;
    if (out_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_on && r < 25) begin
      stall_left <= (r < 3) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted read byte with the oldest expected one
  always @(posedge clk) begin : check_read_data
    read_expect_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (read_data_q.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("%0t: unexpected read result 0x%02h", $time, out_read_data);
        end
        mismatches++;
      end else begin
        want = read_data_q.pop_front();
        n_checked++;
        if (out_read_data !== want.data) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: byte %0d read 0x%02h, expected 0x%02h",
                     $time, want.index, out_read_data, want.data);
          end
          mismatches++;
        end
      end
    end
  end

  // Field extremes, scale limits, clipping on every edge, clear and the
  // ignored code, all back to back
  task automatic test_directed();
    glyph_t solid, stripes, column;
    solid   = '1;
    stripes = {7'h55, 7'h2A, 7'h55, 7'h2A, 7'h55};
    column  = '0;
    column[0] = '1;
    gaps_on  = 1'b0;
    stall_on <= 1'b0;
    send_item(read_item(0));
    send_item(read_item(sgb_pkg::STORE_BYTES - 1));
    send_item(draw_item(1'b1, 0, 0, 1, solid));
    send_item(read_item(0));
    send_item(read_item(4));
    // origin and scale are ignored without the start flag
    send_item(draw_item(1'b0, -200, 100, 9, stripes));
    send_item(read_item(6));
    send_item(read_item(10));
    send_item(draw_item(1'b1, -3, -3, 0, solid));
    send_item(read_item(0));
    send_item(draw_item(1'b1, sgb_pkg::SCREEN_WIDTH - 3, sgb_pkg::SCREEN_HEIGHT - 4, 2,
                        solid));
    send_item(read_item(sgb_pkg::STORE_BYTES - 1));
    send_item(draw_item(1'b1, -512, -256, 15, solid));
    send_item(draw_item(1'b1, 511, 255, sgb_pkg::MAX_SCALE, solid));
    send_item(draw_item(1'b1, 40, 8, 15, column));
    send_item(read_item(sgb_pkg::SCREEN_WIDTH + 47));
    send_item(read_item((sgb_pkg::NUM_PAGES - 1) * sgb_pkg::SCREEN_WIDTH + 40));
    send_item(draw_item(1'b1, 60, 30, 3, '0));
    send_item(op_item(FN_NONE));
    send_item(read_item(3 * sgb_pkg::SCREEN_WIDTH + 60));
    send_item(op_item(sgb_pkg::FN_CLEAR));
    send_item(read_item(sgb_pkg::SCREEN_WIDTH + 47));
    // cursor survives the clear
    send_item(draw_item(1'b0, 0, 0, 0, solid));
    send_item(read_item(3 * sgb_pkg::SCREEN_WIDTH + 78));
  endtask

  // Text strings: a started glyph, continuation glyphs, then reads over the
  // area drawn; some strings run off the right edge until the cursor pins
  task automatic test_text_runs(input int runs);
    sgb_pkg::item_t it;
    int x0, y0, s, len, span, col, page, n_rd;
    for (int k = 0; k < runs; k++) begin
      gaps_on  = ($urandom_range(3) != 0);
      stall_on <= ($urandom_range(3) != 0);
      if ($urandom_range(39) == 0) send_item(op_item(sgb_pkg::FN_CLEAR));
      if ($urandom_range(9) == 0) begin
        x0  = $urandom_range(380, 511);
        s   = $urandom_range(7, 15);
        len = $urandom_range(12, 20);
      end else begin
        x0  = int'($urandom_range(0, 160)) - 24;
        s   = rand_scale();
        len = $urandom_range(1, 8);
      end
      if ($urandom_range(9) == 0) begin
        y0 = int'($urandom_range(0, 511)) - 256;
      end else begin
        y0 = int'($urandom_range(0, 72)) - 8;
      end
      for (int g = 0; g < len; g++) begin
        it = rand_item();
        it.func       = sgb_pkg::FN_DRAW;
        it.start_text = (g == 0);
        if (g == 0) begin
          it.origin_x    = sgb_pkg::OX_W'(x0);
          it.origin_y    = sgb_pkg::OY_W'(y0);
          it.pixel_scale = sgb_pkg::SCALE_W'(s);
        end
        send_item(it);
        // now and then a stray read or ignored item inside the string
        if ($urandom_range(19) == 0) begin
          it = rand_item();
          it.func = ($urandom_range(1) == 0) ? sgb_pkg::FN_READ : FN_NONE;
          send_item(it);
        end
      end
      span = 6 * text_scale * len;
      n_rd = $urandom_range(2, 6);
      for (int q = 0; q < n_rd; q++) begin
        col = x0 + int'($urandom_range(0, span));
        if (col < 0 || col >= sgb_pkg::SCREEN_WIDTH) begin
          col = $urandom_range(0, sgb_pkg::SCREEN_WIDTH - 1);
        end
        page = (y0 + int'($urandom_range(0, 7 * text_scale))) / 8;
        if (page < 0 || page >= sgb_pkg::NUM_PAGES) begin
          page = $urandom_range(0, sgb_pkg::NUM_PAGES - 1);
        end
        send_item(read_item(page * sgb_pkg::SCREEN_WIDTH + col));
      end
    end
  endtask

  // Block the output for a long stretch while reads keep coming, so the
  // output register fills and the input backs up
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    stall_on <= 1'b0;
    fork
      begin
        out_hold <= 1'b1;
        repeat (400) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    for (int k = 0; k < 50; k++) begin
      if ($urandom_range(4) == 0) begin
        send_item(draw_item(1'b1, $urandom_range(0, sgb_pkg::SCREEN_WIDTH - 1),
                            $urandom_range(0, sgb_pkg::SCREEN_HEIGHT - 1), 1,
                            glyph_t'({$urandom, $urandom})));
      end else begin
        send_item(read_item($urandom_range(0, sgb_pkg::STORE_BYTES - 1)));
      end
    end
  endtask

  // Unshaped items: any code, any origin, any scale, any index
  task automatic test_noise(input int count);
    sgb_pkg::item_t it;
    int r;
    gaps_on  = 1'b1;
    stall_on <= 1'b1;
    for (int k = 0; k < count; k++) begin
      it = rand_item();
      r  = $urandom_range(99);
      if (r < 3) begin
        it.func = sgb_pkg::FN_CLEAR;
      end else if (r < 13) begin
        it.func = FN_NONE;
      end else if (r < 55) begin
        it.func = sgb_pkg::FN_READ;
      end else begin
        it.func = sgb_pkg::FN_DRAW;
      end
      send_item(it);
    end
  endtask

  initial begin : run_tests
    int drain;
    foreach (fb_image[i]) fb_image[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_text_runs(80);
    test_backpressure();
    test_noise(200);
    test_text_runs(20);

    // Drain outstanding reads, then let any slow draw or clear finish
    in_valid <= 1'b0;
    stall_on <= 1'b0;
    drain = 0;
    while (read_data_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (1100) @(posedge clk);
    if (read_data_q.size() != 0) begin
      $display("%0d read results never arrived", read_data_q.size());
      mismatches += read_data_q.size();
    end

    $display("covered %0d draws in %0d text runs (cursor pinned %0d times),",
             n_draws, n_runs, n_pinned);
    $display("  %0d clears, %0d ignored; checked %0d of %0d reads (%0d non-zero);",
             n_clears, n_ignored, n_checked, n_reads, n_busy_reads);
    $display("  input backed up %0d cycles under hold-off", n_held_back);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin : watchdog
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sgb_pkg.sv
src/sgb_ram.sv
src/sgb_window.sv
src/sgb_engine.sv
src/scaled_glyph_blitter_core.sv
sim/scaled_glyph_blitter_core_test.sv
